### src/bba_pkg.sv
// ============================================================================
// bba_pkg: shared definitions for the block bitmap allocator
// Field widths, operation and status codes, controller states and defaults.
// ============================================================================
package bba_pkg;

    // Default sizing of the bitmap.
    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;

    // Field widths of the stream beats and the configuration register.
    localparam int OP_W      = 2;
    localparam int BLK_W     = 12;
    localparam int WIDX_W    = 7;
    localparam int WDATA_W   = 32;
    localparam int CNT_W     = 13;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 16;

    // Block count after reset.
    localparam int COUNT_RESET = 4096;

    // Fraction bits of the reciprocal used to split a block number.
    localparam int RECIP_SHIFT = 16;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_SPACE   = 2'd1,
        STAT_FREE_ZERO  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        FSM_CLEAR  = 3'd0,
        FSM_IDLE   = 3'd1,
        FSM_DIVQ   = 3'd2,
        FSM_DIVR   = 3'd3,
        FSM_READ   = 3'd4,
        FSM_APPLY  = 3'd5,
        FSM_SCAN   = 3'd6,
        FSM_FINISH = 3'd7
    } state_t;

endpackage

### src/block_bitmap_allocator_top.sv
// ============================================================================
// block_bitmap_allocator_top: first-fit free-block bitmap allocator
// Keeps a free bitmap in a synchronous memory and serves query, allocate,
// free and word-load commands, one command at a time.
// ============================================================================
// The free bitmap (a set bit means the block is free) lives in one memory of
// ceil(MAX_BLOCKS / WORD_BITS) words with a registered read. After reset the
// block clears the memory one bitmap word at a time and accepts no command
// beat during that pass; the configuration port is always ready. Commands
// are handled one at a time; a query or a free splits the block number into
// word and bit, reads the memory, sets or samples the bit, and loads the
// result. Allocate reads one bitmap word per cycle from word zero upward
// until it finds a free block below the usable count. The next command beat
// is taken while a finished result still waits in the output register.
module block_bitmap_allocator_top #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Command beat, from bit 0 up: op[1:0], block_number[13:2],
    // word_index[20:14], word_data[52:21], zero fill [55:53].
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bba_pkg::S_TDATA_W-1:0] s_tdata,
    // Result beat, from bit 0 up: status[1:0], is_free[2],
    // allocated_block[14:3], zero fill [15].
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bba_pkg::M_TDATA_W-1:0] m_tdata,
    // Block count register write.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bba_pkg::CNT_W-1:0]     cfg_data
);
    import bba_pkg::*;

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    // Width of block positions, wide enough for one word past the map end.
    localparam int CW        = $clog2(MAP_WORDS * WORD_BITS + WORD_BITS + 1);
    localparam int EW        = (CW > CNT_W) ? CW : CNT_W;
    localparam int XW        = (AW > BLK_W) ? AW : BLK_W;
    localparam int GW        = (CW > BLK_W) ? CW : BLK_W;
    localparam int RECIP     = (1 << RECIP_SHIFT) / WORD_BITS;
    localparam int RW        = $clog2(RECIP + 1);
    localparam int PW        = BLK_W + RW;
    localparam int MW        = BLK_W + BW + 1;

    localparam logic [EW-1:0] MAX_E     = EW'(MAX_BLOCKS);
    localparam logic [CW-1:0] EFF_RESET =
        CW'((MAX_BLOCKS < COUNT_RESET) ? MAX_BLOCKS : COUNT_RESET);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    op_t                    op_reg;
    logic [BLK_W-1:0]       blk_reg;
    logic [WIDX_W-1:0]      widx_reg;
    logic [WDATA_W-1:0]     wdata_reg;
    logic [CW-1:0]          eff_reg;
    logic [AW-1:0]          clr_reg, clr_next;
    logic [BLK_W-1:0]       qest_reg, qest_next;
    logic [AW-1:0]          word_reg, word_next;
    logic [BW-1:0]          bit_reg, bit_next;
    logic [AW-1:0]          iss_word_reg, iss_word_next;
    logic [CW-1:0]          iss_base_reg, iss_base_next;
    logic                   chk_valid_reg, chk_valid_next;
    logic [AW-1:0]          chk_word_reg, chk_word_next;
    logic [CW-1:0]          chk_base_reg, chk_base_next;
    logic [WORD_BITS-1:0]   rd_data_reg;
    status_t                res_status_reg, res_status_next;
    logic                   res_free_reg, res_free_next;
    logic [BLK_W-1:0]       res_blk_reg, res_blk_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // Memory ports.
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [WORD_BITS-1:0]   mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [WORD_BITS-1:0]   mem [MAP_WORDS];

    // Configuration: the count is clamped to the map size when written.
    logic [EW-1:0]          cfg_ext, cfg_min;
    logic [CW-1:0]          cfg_eff;

    assign cfg_ready = 1'b1;
    assign cfg_ext   = EW'(cfg_data);
    assign cfg_min   = (cfg_ext > MAX_E) ? MAX_E : cfg_ext;
    assign cfg_eff   = cfg_min[CW-1:0];

    assign s_tready  = (state_reg == FSM_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // ------------------------------------------------------------------
    // Block number split: quotient estimate by reciprocal, then one
    // correcting subtract since the estimate is at most one short.
    // ------------------------------------------------------------------
    logic [PW-1:0]          div_prod, div_shift;
    logic [MW-1:0]          div_qw, div_rem, div_rfix;
    logic                   div_over;
    logic [BLK_W-1:0]       div_qfix;
    logic [XW-1:0]          div_qx;
    logic                   blk_in_map, blk_in_count;

    assign div_prod     = PW'(blk_reg) * PW'(RECIP);
    assign div_shift    = div_prod >> RECIP_SHIFT;
    assign qest_next    = div_shift[BLK_W-1:0];
    assign div_qw       = MW'(qest_reg) * MW'(WORD_BITS);
    assign div_rem      = MW'(blk_reg) - div_qw;
    assign div_over     = (div_rem >= MW'(WORD_BITS));
    assign div_qfix     = div_over ? (qest_reg + BLK_W'(1)) : qest_reg;
    assign div_rfix     = div_over ? (div_rem - MW'(WORD_BITS)) : div_rem;
    assign div_qx       = XW'(div_qfix);
    assign word_next    = div_qx[AW-1:0];
    assign bit_next     = div_rfix[BW-1:0];
    assign blk_in_map   = (EW'(blk_reg) < MAX_E);
    assign blk_in_count = (EW'(blk_reg) < EW'(eff_reg));

    // ------------------------------------------------------------------
    // Scan check: mask the fetched word to blocks below the count and
    // pick its lowest set bit.
    // ------------------------------------------------------------------
    logic [CW-1:0]          scan_rem;
    logic [WORD_BITS-1:0]   scan_lim, scan_cand, scan_low;
    logic [BW-1:0]          scan_idx;
    logic                   scan_hit, scan_last, scan_go;
    logic [CW-1:0]          scan_blk;
    logic [GW-1:0]          scan_blk_x;

    assign scan_rem = eff_reg - chk_base_reg;

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            scan_lim[i] = (CW'(i) < scan_rem);
        end
    end

    assign scan_cand = rd_data_reg & scan_lim;
    assign scan_low  = scan_cand & (~scan_cand + WORD_BITS'(1));
    assign scan_hit  = |scan_cand;

    always_comb begin
        scan_idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            scan_idx = scan_idx | (scan_low[i] ? BW'(i) : BW'(0));
        end
    end

    assign scan_blk   = chk_base_reg + CW'(scan_idx);
    assign scan_blk_x = GW'(scan_blk);
    assign scan_last  = (scan_rem <= CW'(WORD_BITS));
    assign scan_go    = (state_reg == FSM_SCAN) && (iss_base_reg < eff_reg);

    // Word load helpers.
    logic                   widx_ok;
    logic [XW-1:0]          widx_x;
    logic [63:0]            wdata_x;
    logic [WORD_BITS-1:0]   bit_mask;

    assign widx_ok  = (32'(widx_reg) < 32'(MAP_WORDS));
    assign widx_x   = XW'(widx_reg);
    assign wdata_x  = 64'(wdata_reg);
    assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_reg;

    assign mem_raddr = (state_reg == FSM_SCAN) ? iss_word_reg : word_reg;

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        iss_word_next   = iss_word_reg;
        iss_base_next   = iss_base_reg;
        chk_valid_next  = 1'b0;
        chk_word_next   = iss_word_reg;
        chk_base_next   = iss_base_reg;
        res_status_next = res_status_reg;
        res_free_next   = res_free_reg;
        res_blk_next    = res_blk_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        mem_we          = 1'b0;
        mem_waddr       = chk_word_reg;
        mem_wdata       = rd_data_reg & ~scan_low;

        case (state_reg)
            FSM_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == AW'(MAP_WORDS - 1)) begin
                    state_next = FSM_IDLE;
                end else begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            FSM_IDLE: begin
                if (s_tvalid) begin
                    state_next = FSM_DIVQ;
                end
            end
            FSM_DIVQ: begin
                res_status_next = STAT_OK;
                res_free_next   = 1'b0;
                res_blk_next    = '0;
                iss_word_next   = '0;
                iss_base_next   = '0;
                case (op_reg)
                    OP_ALLOC: begin
                        if (eff_reg == '0) begin
                            res_status_next = STAT_NO_SPACE;
                            state_next      = FSM_FINISH;
                        end else begin
                            state_next = FSM_SCAN;
                        end
                    end
                    OP_WRITE: begin
                        mem_we     = widx_ok;
                        mem_waddr  = widx_x[AW-1:0];
                        mem_wdata  = wdata_x[WORD_BITS-1:0];
                        state_next = FSM_FINISH;
                    end
                    default: begin
                        state_next = FSM_DIVR;
                    end
                endcase
            end
            FSM_DIVR: begin
                if (op_reg == OP_QUERY) begin
                    state_next = blk_in_count ? FSM_READ : FSM_FINISH;
                end else if (blk_reg == '0) begin
                    res_status_next = STAT_FREE_ZERO;
                    state_next      = FSM_FINISH;
                end else begin
                    state_next = blk_in_map ? FSM_READ : FSM_FINISH;
                end
            end
            FSM_READ: begin
                state_next = FSM_APPLY;
            end
            FSM_APPLY: begin
                if (op_reg == OP_QUERY) begin
                    res_free_next = rd_data_reg[bit_reg];
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = word_reg;
                    mem_wdata = rd_data_reg | bit_mask;
                end
                state_next = FSM_FINISH;
            end
            FSM_SCAN: begin
                // Fetch the next word while the previous one is checked.
                if (scan_go) begin
                    iss_word_next  = iss_word_reg + AW'(1);
                    iss_base_next  = iss_base_reg + CW'(WORD_BITS);
                    chk_valid_next = 1'b1;
                end
                if (chk_valid_reg) begin
                    if (scan_hit) begin
                        mem_we         = 1'b1;
                        res_blk_next   = scan_blk_x[BLK_W-1:0];
                        chk_valid_next = 1'b0;
                        state_next     = FSM_FINISH;
                    end else if (scan_last) begin
                        res_status_next = STAT_NO_SPACE;
                        chk_valid_next  = 1'b0;
                        state_next      = FSM_FINISH;
                    end
                end
            end
            FSM_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({res_blk_reg, res_free_reg, res_status_reg});
                    state_next    = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= FSM_CLEAR;
            clr_reg       <= '0;
            chk_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            eff_reg       <= EFF_RESET;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            chk_valid_reg <= chk_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid) begin
                eff_reg <= cfg_eff;
            end
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg    <= op_t'(s_tdata[1:0]);
            blk_reg   <= s_tdata[13:2];
            widx_reg  <= s_tdata[20:14];
            wdata_reg <= s_tdata[52:21];
        end
        qest_reg       <= qest_next;
        if (state_reg == FSM_DIVR) begin
            word_reg <= word_next;
            bit_reg  <= bit_next;
        end
        iss_word_reg   <= iss_word_next;
        iss_base_reg   <= iss_base_next;
        chk_word_reg   <= chk_word_next;
        chk_base_reg   <= chk_base_next;
        res_status_reg <= res_status_next;
        res_free_reg   <= res_free_next;
        res_blk_reg    <= res_blk_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // Bitmap memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

`ifndef SYNTHESIS
    a_waddr_in_map: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (32'(mem_waddr) < 32'(MAP_WORDS)))
        else $error("bitmap write outside the map");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == FSM_DIVQ))
        else $error("accepted command did not start");

    a_check_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        chk_valid_reg |-> (chk_base_reg < eff_reg))
        else $error("scan checked a word past the block count");

    a_error_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] != STAT_OK)) |-> ((m_tdata[14:2] == '0)))
        else $error("error result carries a block or a free flag");

    a_finish_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == FSM_FINISH) && (!m_tvalid_reg || m_tready))
            |=> (m_tvalid && (state_reg == FSM_IDLE)))
        else $error("finished result not loaded");
`endif

endmodule
